@@ rtl/core/vrt_pkg.sv @@
// Shared types and constants for the voxel ray traversal core.
// Holds the per-ray setup record passed from the setup front end to the stepper.
// No dependencies.
package vrt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 16;
  localparam int T_W       = 32;
  localparam int NUM_W     = 48;
  localparam int DEN_W     = 32;
  localparam int SIZE_W    = 31;
  localparam int LIM_W     = 31;
  localparam int BND_W     = 48;

  localparam logic [T_W-1:0] T_INF = '1;

  localparam logic [1:0] AXIS_START = 2'd0;
  localparam logic [1:0] AXIS_X     = 2'd1;
  localparam logic [1:0] AXIS_Y     = 2'd2;
  localparam logic [1:0] AXIS_Z     = 2'd3;

  localparam logic [2:0] REASON_NONE      = 3'd0;
  localparam logic [2:0] REASON_BOUNDS    = 3'd1;
  localparam logic [2:0] REASON_LIMIT     = 3'd2;
  localparam logic [2:0] REASON_CAP       = 3'd3;
  localparam logic [2:0] REASON_START_OUT = 3'd4;

  localparam logic [2:0] REG_SIZE_X  = 3'd0;
  localparam logic [2:0] REG_SIZE_Y  = 3'd1;
  localparam logic [2:0] REG_SIZE_Z  = 3'd2;
  localparam logic [2:0] REG_LOWER   = 3'd3;
  localparam logic [2:0] REG_UPPER   = 3'd4;
  localparam logic [2:0] REG_BOUNDED = 3'd5;

  typedef struct packed {
    logic [2:0][IDX_W-1:0] cidx;
    logic [2:0][T_W-1:0]   next_t;
    logic [2:0][T_W-1:0]   per_t;
    logic [2:0][1:0]       sign;
    logic [LIM_W-1:0]      limit;
    logic                  start_out;
  } ray_setup_t;

endpackage

@@ rtl/core/voxel_ray_traversal_core.sv @@
// Voxel ray traversal core: setup front end, two-entry queue and cell stepper.
// An accepted ray reaches its first result beat after two 48-step divisions per axis
// in series and the queue hand-off, then the stepper gives one cell per cycle while taken.
// The front end accepts a new ray only after pushing the last setup record into the queue.
// Reset: synchronous active-low; registers return to defaults, no memory sweep.
module voxel_ray_traversal_core #(
  parameter int MAX_CELLS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z, distance_limit
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cell_x, cell_y, cell_z, entry_t, crossed_axis, end_reason
  output logic [87:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [47:0]  cfg_wdata
);

  logic [2:0][vrt_pkg::SIZE_W-1:0] size_r, size_eff;
  logic [vrt_pkg::BND_W-1:0]       lower_r, upper_r;
  logic                            bounded_r;

  logic                            q_full, q_push, q_valid, q_pop;
  vrt_pkg::ray_setup_t             q_wr, q_rd;
  logic [2:0][31:0]                origin, direction;
  logic [2:0][vrt_pkg::IDX_W-1:0]  cidx;
  logic [vrt_pkg::T_W-1:0]         entry_t;
  logic [1:0]                      axis;
  logic [2:0]                      reason;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= {3{31'd65536}};
      lower_r   <= '0;
      upper_r   <= 48'h0010_0010_0010;
      bounded_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        vrt_pkg::REG_SIZE_X:  size_r[0] <= cfg_wdata[vrt_pkg::SIZE_W-1:0];
        vrt_pkg::REG_SIZE_Y:  size_r[1] <= cfg_wdata[vrt_pkg::SIZE_W-1:0];
        vrt_pkg::REG_SIZE_Z:  size_r[2] <= cfg_wdata[vrt_pkg::SIZE_W-1:0];
        vrt_pkg::REG_LOWER:   lower_r   <= cfg_wdata;
        vrt_pkg::REG_UPPER:   upper_r   <= cfg_wdata;
        vrt_pkg::REG_BOUNDED: bounded_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      size_eff[i]  = (size_r[i] == '0) ? vrt_pkg::SIZE_W'(1) : size_r[i];
      origin[i]    = in_tdata[32*i +: 32];
      direction[i] = in_tdata[96 + 32*i +: 32];
    end
  end

  vrt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .origin(origin), .direction(direction), .limit(in_tdata[222:192]),
    .cell_size(size_eff), .lower_bounds(lower_r), .upper_bounds(upper_r),
    .bounded_mode(bounded_r), .q_full(q_full), .q_push(q_push), .q_data(q_wr)
  );

  vrt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wr_data(q_wr), .full(q_full),
    .pop(q_pop), .valid(q_valid), .rd_data(q_rd)
  );

  vrt_back #(.MAX_CELLS(MAX_CELLS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_rd), .q_pop(q_pop),
    .lower_bounds(lower_r), .upper_bounds(upper_r), .bounded_mode(bounded_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_cell(cidx),
    .out_entry_t(entry_t), .out_axis(axis), .out_reason(reason), .out_last(out_tlast)
  );

  assign out_tdata = {3'b000, reason, axis, entry_t, cidx[2], cidx[1], cidx[0]};

endmodule

@@ rtl/core/vrt_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Used by the setup front end for cell index and crossing-time divisions.
// Depends on vrt_pkg.
module vrt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vrt_pkg::NUM_W-1:0]  num,
  input  logic [vrt_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [vrt_pkg::NUM_W-1:0]  quo,
  output logic [vrt_pkg::DEN_W-1:0]  rem
);

  localparam int CNT_W = $clog2(vrt_pkg::NUM_W);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [vrt_pkg::NUM_W-1:0] quo_r, quo_nxt;
  logic [vrt_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [vrt_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [vrt_pkg::DEN_W:0]   trial;
  logic [vrt_pkg::DEN_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[vrt_pkg::NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(vrt_pkg::NUM_W - 1);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!diff[vrt_pkg::DEN_W]) begin
        rem_nxt = diff[vrt_pkg::DEN_W-1:0];
        quo_nxt = {quo_r[vrt_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[vrt_pkg::DEN_W-1:0];
        quo_nxt = {quo_r[vrt_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/vrt_front.sv @@
// Setup front end: accepts a ray, finds its start cell and per-axis crossing times.
// Two dividers per axis; pushes a finished setup record into the queue.
// Depends on vrt_pkg and vrt_div.
module vrt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0][31:0]                    origin,
  input  logic [2:0][31:0]                    direction,
  input  logic [vrt_pkg::LIM_W-1:0]           limit,
  input  logic [2:0][vrt_pkg::SIZE_W-1:0]     cell_size,
  input  logic [vrt_pkg::BND_W-1:0]           lower_bounds,
  input  logic [vrt_pkg::BND_W-1:0]           upper_bounds,
  input  logic                                bounded_mode,
  input  logic                                q_full,
  output logic                                q_push,
  output vrt_pkg::ray_setup_t                 q_data
);

  typedef enum logic [1:0] {F_IDLE, F_FLOOR, F_NEXT, F_PUSH} state_t;

  state_t                              state_r;
  logic                                start_a_r, start_b_r;
  logic [2:0][31:0]                    o_r, d_r;
  logic [vrt_pkg::LIM_W-1:0]           limit_r;
  logic [2:0][33:0]                    q_r;
  logic [2:0][vrt_pkg::SIZE_W-1:0]     rf_r;
  logic [2:0][vrt_pkg::T_W-1:0]        next_r, per_r;

  logic [2:0]                          done_a, done_b;
  logic [2:0][vrt_pkg::NUM_W-1:0]      quo_a, quo_b, num_a, num_b;
  logic [2:0][vrt_pkg::DEN_W-1:0]      rem_a, rem_b, den_a, den_b;
  logic [2:0][31:0]                    abs_o, abs_d;
  logic [2:0][33:0]                    q_new;
  logic [2:0][vrt_pkg::SIZE_W-1:0]     rf_new, span;
  logic [2:0][vrt_pkg::T_W-1:0]        sat_a, sat_b;
  logic                                inb;

  always_comb begin
    inb = 1'b1;
    for (int i = 0; i < 3; i++) begin
      abs_o[i] = o_r[i][31] ? (~o_r[i] + 32'd1) : o_r[i];
      abs_d[i] = d_r[i][31] ? (~d_r[i] + 32'd1) : d_r[i];
      if (o_r[i][31]) begin
        q_new[i]  = 34'd0 - {1'b0, quo_a[i][32:0]}
                    - {33'd0, (rem_a[i][vrt_pkg::SIZE_W-1:0] != '0)};
        rf_new[i] = (rem_a[i][vrt_pkg::SIZE_W-1:0] != '0)
                    ? cell_size[i] - rem_a[i][vrt_pkg::SIZE_W-1:0] : '0;
      end else begin
        q_new[i]  = {1'b0, quo_a[i][32:0]};
        rf_new[i] = rem_a[i][vrt_pkg::SIZE_W-1:0];
      end
      span[i] = d_r[i][31] ? rf_r[i] : cell_size[i] - rf_r[i];
      if (state_r == F_NEXT) begin
        num_a[i] = {1'b0, span[i], vrt_pkg::FRAC_BITS'(0)};
        den_a[i] = abs_d[i];
      end else begin
        num_a[i] = {16'd0, abs_o[i]};
        den_a[i] = {1'b0, cell_size[i]};
      end
      num_b[i] = {1'b0, cell_size[i], vrt_pkg::FRAC_BITS'(0)};
      den_b[i] = abs_d[i];
      sat_a[i] = (quo_a[i][vrt_pkg::NUM_W-1:vrt_pkg::T_W] != '0)
                 ? vrt_pkg::T_INF : quo_a[i][vrt_pkg::T_W-1:0];
      sat_b[i] = (quo_b[i][vrt_pkg::NUM_W-1:vrt_pkg::T_W] != '0)
                 ? vrt_pkg::T_INF : quo_b[i][vrt_pkg::T_W-1:0];
      if ($signed(q_r[i]) < $signed({{18{lower_bounds[16*i+15]}}, lower_bounds[16*i +: 16]}))
        inb = 1'b0;
      if ($signed(q_r[i]) >= $signed({{18{upper_bounds[16*i+15]}}, upper_bounds[16*i +: 16]}))
        inb = 1'b0;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    vrt_div u_div_a (
      .clk(clk), .rst_n(rst_n), .start(start_a_r), .num(num_a[g]), .den(den_a[g]),
      .done(done_a[g]), .quo(quo_a[g]), .rem(rem_a[g])
    );
    vrt_div u_div_b (
      .clk(clk), .rst_n(rst_n), .start(start_b_r), .num(num_b[g]), .den(den_b[g]),
      .done(done_b[g]), .quo(quo_b[g]), .rem(rem_b[g])
    );
  end

  always_comb begin
    q_data.limit     = limit_r;
    q_data.start_out = bounded_mode && !inb;
    for (int i = 0; i < 3; i++) begin
      if ($signed(q_r[i]) > 34'sd32767)
        q_data.cidx[i] = 16'h7FFF;
      else if ($signed(q_r[i]) < -34'sd32768)
        q_data.cidx[i] = 16'h8000;
      else
        q_data.cidx[i] = q_r[i][vrt_pkg::IDX_W-1:0];
      if (d_r[i] == '0) begin
        q_data.next_t[i] = vrt_pkg::T_INF;
        q_data.per_t[i]  = vrt_pkg::T_INF;
        q_data.sign[i]   = 2'b00;
      end else begin
        q_data.next_t[i] = next_r[i];
        q_data.per_t[i]  = per_r[i];
        q_data.sign[i]   = d_r[i][31] ? 2'b11 : 2'b01;
      end
    end
  end

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      start_a_r <= 1'b0;
      start_b_r <= 1'b0;
    end else begin
      start_a_r <= 1'b0;
      start_b_r <= 1'b0;
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            state_r   <= F_FLOOR;
            start_a_r <= 1'b1;
            start_b_r <= 1'b1;
          end
        end
        F_FLOOR: begin
          if (done_a[0]) begin
            state_r   <= F_NEXT;
            start_a_r <= 1'b1;
          end
        end
        F_NEXT: begin
          if (done_a[0]) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
    if (in_valid && state_r == F_IDLE) begin
      o_r     <= origin;
      d_r     <= direction;
      limit_r <= limit;
    end
    for (int i = 0; i < 3; i++) begin
      if (done_a[0] && state_r == F_FLOOR) begin
        q_r[i]  <= q_new[i];
        rf_r[i] <= rf_new[i];
      end
      if (done_a[0] && state_r == F_NEXT) next_r[i] <= sat_a[i];
      if (done_b[i]) per_r[i] <= sat_b[i];
    end
  end

endmodule

@@ rtl/core/vrt_queue.sv @@
// Two-entry queue of ray setup records between the setup front end and the stepper.
// Depends on vrt_pkg.
module vrt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vrt_pkg::ray_setup_t wr_data,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output vrt_pkg::ray_setup_t rd_data
);

  vrt_pkg::ray_setup_t mem_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          count_r;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ rtl/core/vrt_back.sv @@
// Traversal stepper: walks one cell per cycle (stalled by out_ready)
// from a setup record, drives the registered result beat. Depends on vrt_pkg.
module vrt_back #(
  parameter int MAX_CELLS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  vrt_pkg::ray_setup_t            q_data,
  output logic                           q_pop,
  input  logic [vrt_pkg::BND_W-1:0]      lower_bounds,
  input  logic [vrt_pkg::BND_W-1:0]      upper_bounds,
  input  logic                           bounded_mode,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0][vrt_pkg::IDX_W-1:0] out_cell,
  output logic [vrt_pkg::T_W-1:0]        out_entry_t,
  output logic [1:0]                     out_axis,
  output logic [2:0]                     out_reason,
  output logic                           out_last
);

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  logic                           active_r, start_out_r;
  logic [2:0][vrt_pkg::IDX_W-1:0] cur_r;
  logic [2:0][vrt_pkg::T_W-1:0]   nxt_r, per_r;
  logic [2:0][1:0]                sign_r;
  logic [vrt_pkg::LIM_W-1:0]      limit_r;
  logic [vrt_pkg::T_W-1:0]        t_entry_r;
  logic [1:0]                     axis_r;
  logic [CNT_W-1:0]               k_r;
  logic                           out_valid_r, out_last_r;
  logic [2:0][vrt_pkg::IDX_W-1:0] out_cell_r;
  logic [vrt_pkg::T_W-1:0]        out_t_r;
  logic [1:0]                     out_axis_r;
  logic [2:0]                     out_reason_r;

  logic [1:0]                     sel;
  logic [1:0]                     sel_axis;
  logic [vrt_pkg::T_W-1:0]        tc;
  logic [vrt_pkg::IDX_W-1:0]      nc;
  logic [2:0][vrt_pkg::IDX_W-1:0] probe;
  logic                           inb;
  logic [vrt_pkg::T_W:0]          sum;
  logic [2:0]                     reason;
  logic                           emit;

  always_comb begin
    if (nxt_r[0] < nxt_r[1] && nxt_r[0] < nxt_r[2]) begin
      sel = 2'd0;
      sel_axis = vrt_pkg::AXIS_X;
    end else if (nxt_r[1] < nxt_r[2]) begin
      sel = 2'd1;
      sel_axis = vrt_pkg::AXIS_Y;
    end else begin
      sel = 2'd2;
      sel_axis = vrt_pkg::AXIS_Z;
    end
    tc  = nxt_r[sel];
    nc  = cur_r[sel] + {{(vrt_pkg::IDX_W-2){sign_r[sel][1]}}, sign_r[sel]};
    sum = {1'b0, tc} + {1'b0, per_r[sel]};
    inb = 1'b1;
    for (int i = 0; i < 3; i++) begin
      probe[i] = (sel == 2'(i)) ? nc : cur_r[i];
      if ($signed(probe[i]) < $signed(lower_bounds[16*i +: 16])) inb = 1'b0;
      if ($signed(probe[i]) >= $signed(upper_bounds[16*i +: 16])) inb = 1'b0;
    end
    if (start_out_r)
      reason = vrt_pkg::REASON_START_OUT;
    else if (tc > {1'b0, limit_r})
      reason = vrt_pkg::REASON_LIMIT;
    else if (bounded_mode && !inb)
      reason = vrt_pkg::REASON_BOUNDS;
    else if ((CNT_W+1)'(k_r) + 1'b1 >= (CNT_W+1)'(MAX_CELLS))
      reason = vrt_pkg::REASON_CAP;
    else
      reason = vrt_pkg::REASON_NONE;
  end

  assign emit  = active_r && (!out_valid_r || out_ready);
  assign q_pop = !active_r && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (emit && reason != vrt_pkg::REASON_NONE) begin
        active_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      cur_r       <= q_data.cidx;
      nxt_r       <= q_data.next_t;
      per_r       <= q_data.per_t;
      sign_r      <= q_data.sign;
      limit_r     <= q_data.limit;
      start_out_r <= q_data.start_out;
      t_entry_r   <= '0;
      axis_r      <= vrt_pkg::AXIS_START;
      k_r         <= '0;
    end else if (emit) begin
      out_cell_r   <= cur_r;
      out_t_r      <= t_entry_r;
      out_axis_r   <= axis_r;
      out_reason_r <= reason;
      out_last_r   <= (reason != vrt_pkg::REASON_NONE);
      if (reason == vrt_pkg::REASON_NONE) begin
        cur_r[sel] <= nc;
        nxt_r[sel] <= sum[vrt_pkg::T_W] ? vrt_pkg::T_INF : sum[vrt_pkg::T_W-1:0];
        t_entry_r  <= tc;
        axis_r     <= sel_axis;
        k_r        <= k_r + 1'b1;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cell    = out_cell_r;
  assign out_entry_t = out_t_r;
  assign out_axis    = out_axis_r;
  assign out_reason  = out_reason_r;
  assign out_last    = out_last_r;

`ifndef SYNTH
  a_last_iff_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_reason_r != vrt_pkg::REASON_NONE)))
    else $error("last flag disagrees with end reason");
  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ((CNT_W+1)'(k_r) < (CNT_W+1)'(MAX_CELLS)))
    else $error("cell count passed the cap");
  a_start_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reason_r == vrt_pkg::REASON_START_OUT) |->
      (out_axis_r == vrt_pkg::AXIS_START && out_t_r == '0))
    else $error("start-outside result is not a start cell");
  a_no_pop_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !q_pop)
    else $error("setup popped during a run");
`endif

endmodule
